// ===== rtl/core/cau_pkg.sv =====
// shared types and constants for the complex arithmetic unit
// no dependencies
`default_nettype none

package cau_pkg;

   localparam int CAU_DATA_WIDTH  = 32;
   localparam int CAU_FRAC_BITS   = 16;
   localparam int CAU_QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   // classification made by the front end
   typedef struct packed {
      cmd_type cmd;
      logic    dz;
   } ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/cau_front.sv =====
// front end: input register, classifies each beat and pushes it to the queue
// depends on cau_pkg
`default_nettype none

module cau_front #(
   parameter int W = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_stall,
   input  wire logic [1:0]      in_cmd,
   input  wire logic [W-1:0]    in_ar,
   input  wire logic [W-1:0]    in_ai,
   input  wire logic [W-1:0]    in_br,
   input  wire logic [W-1:0]    in_bi,
   output logic                 push,
   input  wire logic            q_full,
   output cau_pkg::ctrl_type    out_ctrl,
   output logic [W-1:0]         out_ar,
   output logic [W-1:0]         out_ai,
   output logic [W-1:0]         out_br,
   output logic [W-1:0]         out_bi
);
   import cau_pkg::*;

   logic      valid_ff, valid_in;
   ctrl_type  ctrl_ff, ctrl_in;
   logic      accept;

   assign push     = valid_ff && !q_full;
   assign in_stall = valid_ff && q_full;
   assign accept   = in_valid && !in_stall;

   always_comb begin
      ctrl_in.cmd = cmd_type'(in_cmd);
      ctrl_in.dz  = (ctrl_in.cmd == CMD_DIV) && (in_br == '0) && (in_bi == '0);
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctrl_ff <= ctrl_in;
         out_ar  <= in_ar;
         out_ai  <= in_ai;
         out_br  <= in_br;
         out_bi  <= in_bi;
      end
   end

   assign out_ctrl = ctrl_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cau_queue.sv =====
// short fifo between front end and back end
// no dependencies
`default_nettype none

module cau_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  not_empty,
   output logic [WIDTH-1:0]      pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cau_div.sv =====
// pipelined restoring divider lane, one quotient bit per stage
// no dependencies
`default_nettype none

module cau_div #(
   parameter int NUM_W = 80,
   parameter int DEN_W = 64
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0]      quo
);
   // nq holds remaining numerator bits at the top, quotient bits fill in below
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] nq_ff  [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];

   for (genvar g = 0; g < NUM_W; g++) begin : g_stage
      logic [DEN_W-1:0] rem_src, den_src, rem_in;
      logic [NUM_W-1:0] nq_src, nq_in;
      logic [DEN_W:0]   trial, diff;
      logic             ge;

      if (g == 0) begin : g_first
         assign rem_src = '0;
         assign nq_src  = num;
         assign den_src = den;
      end else begin : g_next
         assign rem_src = rem_ff[g-1];
         assign nq_src  = nq_ff[g-1];
         assign den_src = den_ff[g-1];
      end

      always_comb begin
         trial  = {rem_src, nq_src[NUM_W-1]};
         ge     = (trial >= {1'b0, den_src});
         diff   = trial - {1'b0, den_src};
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         nq_in  = {nq_src[NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g] <= rem_in;
            nq_ff[g]  <= nq_in;
            den_ff[g] <= den_src;
         end
      end
   end

   assign quo = nq_ff[NUM_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/cau_back.sv =====
// back end: products, sums, magnitudes, divider lanes, saturation, output register
// depends on cau_pkg and cau_div
`default_nettype none

module cau_back #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire cau_pkg::ctrl_type in_ctrl,
   input  wire logic [W-1:0]  in_ar,
   input  wire logic [W-1:0]  in_ai,
   input  wire logic [W-1:0]  in_br,
   input  wire logic [W-1:0]  in_bi,
   output logic               out_valid,
   input  wire logic          out_stall,
   output logic [W-1:0]       out_re,
   output logic [W-1:0]       out_im,
   output logic               out_ov,
   output logic               out_dz
);
   import cau_pkg::*;

   localparam int P_W = 2 * W;
   localparam int S_W = 2 * W + 1;
   localparam int M_W = 2 * W + F;
   localparam logic [M_W-1:0] POS_LIM = (M_W'(1) << (W - 1)) - M_W'(1);
   localparam logic [M_W-1:0] NEG_LIM = M_W'(1) << (W - 1);

   logic en;
   logic out_valid_ff;

   assign en        = !out_valid_ff || !out_stall;
   assign in_ready  = en;
   assign out_valid = out_valid_ff;

   // stage a: products and add/sub sums
   logic signed [W-1:0]   ar_s, ai_s, br_s, bi_s;
   logic signed [P_W-1:0] rr_p, ii_p, ri_p, ir_p, brr_p, bii_p;
   logic signed [W:0]     re_as, im_as;

   assign ar_s  = in_ar;
   assign ai_s  = in_ai;
   assign br_s  = in_br;
   assign bi_s  = in_bi;
   assign rr_p  = ar_s * br_s;
   assign ii_p  = ai_s * bi_s;
   assign ri_p  = ar_s * bi_s;
   assign ir_p  = ai_s * br_s;
   assign brr_p = br_s * br_s;
   assign bii_p = bi_s * bi_s;

   always_comb begin
      if (in_ctrl.cmd == CMD_SUB) begin
         re_as = (W+1)'(ar_s) - (W+1)'(br_s);
         im_as = (W+1)'(ai_s) - (W+1)'(bi_s);
      end else begin
         re_as = (W+1)'(ar_s) + (W+1)'(br_s);
         im_as = (W+1)'(ai_s) + (W+1)'(bi_s);
      end
   end

   logic                  a_valid_ff;
   ctrl_type              a_ctrl_ff;
   logic signed [P_W-1:0] a_rr_ff, a_ii_ff, a_ri_ff, a_ir_ff;
   logic [P_W-1:0]        a_brr_ff, a_bii_ff;
   logic signed [W:0]     a_re_ff, a_im_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a_ctrl_ff <= in_ctrl;
         a_rr_ff   <= rr_p;
         a_ii_ff   <= ii_p;
         a_ri_ff   <= ri_p;
         a_ir_ff   <= ir_p;
         a_brr_ff  <= brr_p;
         a_bii_ff  <= bii_p;
         a_re_ff   <= re_as;
         a_im_ff   <= im_as;
      end
   end

   // stage b: signed sums and squared divisor magnitude
   logic signed [S_W-1:0] re_b, im_b;

   always_comb begin
      unique case (a_ctrl_ff.cmd)
         CMD_ADD, CMD_SUB: begin
            re_b = S_W'(a_re_ff);
            im_b = S_W'(a_im_ff);
         end
         CMD_MUL: begin
            re_b = S_W'(a_rr_ff) - S_W'(a_ii_ff);
            im_b = S_W'(a_ri_ff) + S_W'(a_ir_ff);
         end
         CMD_DIV: begin
            re_b = S_W'(a_rr_ff) + S_W'(a_ii_ff);
            im_b = S_W'(a_ir_ff) - S_W'(a_ri_ff);
         end
         default: begin
            re_b = '0;
            im_b = '0;
         end
      endcase
   end

   logic                  b_valid_ff;
   ctrl_type              b_ctrl_ff;
   logic signed [S_W-1:0] b_re_ff, b_im_ff;
   logic [P_W-1:0]        b_den_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         b_ctrl_ff <= a_ctrl_ff;
         b_re_ff   <= re_b;
         b_im_ff   <= im_b;
         b_den_ff  <= a_brr_ff + a_bii_ff;
      end
   end

   // stage c: sign and magnitude, numerator alignment; non-divide beats divide by one
   logic [S_W-1:0] re_abs, im_abs;
   logic [M_W-1:0] re_num, im_num;
   logic [P_W-1:0] den_c;

   always_comb begin
      re_abs = b_re_ff[S_W-1] ? S_W'(-b_re_ff) : S_W'(b_re_ff);
      im_abs = b_im_ff[S_W-1] ? S_W'(-b_im_ff) : S_W'(b_im_ff);
      unique case (b_ctrl_ff.cmd)
         CMD_MUL: begin
            re_num = M_W'(re_abs[P_W-1:0] >> F);
            im_num = M_W'(im_abs[P_W-1:0] >> F);
            den_c  = P_W'(1);
         end
         CMD_DIV: begin
            re_num = M_W'(re_abs[P_W-1:0]) << F;
            im_num = M_W'(im_abs[P_W-1:0]) << F;
            den_c  = b_ctrl_ff.dz ? P_W'(1) : b_den_ff;
         end
         default: begin
            re_num = M_W'(re_abs[P_W-1:0]);
            im_num = M_W'(im_abs[P_W-1:0]);
            den_c  = P_W'(1);
         end
      endcase
   end

   logic           c_valid_ff;
   ctrl_type       c_ctrl_ff;
   logic           c_neg_re_ff, c_neg_im_ff;
   logic [M_W-1:0] c_re_num_ff, c_im_num_ff;
   logic [P_W-1:0] c_den_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c_ctrl_ff   <= b_ctrl_ff;
         c_neg_re_ff <= b_re_ff[S_W-1];
         c_neg_im_ff <= b_im_ff[S_W-1];
         c_re_num_ff <= re_num;
         c_im_num_ff <= im_num;
         c_den_ff    <= den_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   // divider lanes
   logic [M_W-1:0] re_quo, im_quo;

   cau_div #(.NUM_W(M_W), .DEN_W(P_W)) u_div_re (
      .clock (clock),
      .en    (en),
      .num   (c_re_num_ff),
      .den   (c_den_ff),
      .quo   (re_quo)
   );

   cau_div #(.NUM_W(M_W), .DEN_W(P_W)) u_div_im (
      .clock (clock),
      .en    (en),
      .num   (c_im_num_ff),
      .den   (c_den_ff),
      .quo   (im_quo)
   );

   // side information travelling beside the divider lanes
   logic     d_valid_ff  [M_W];
   ctrl_type d_ctrl_ff   [M_W];
   logic     d_neg_re_ff [M_W];
   logic     d_neg_im_ff [M_W];

   for (genvar g = 0; g < M_W; g++) begin : g_side
      if (g == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               d_valid_ff[g] <= 1'b0;
            end else if (en) begin
               d_valid_ff[g] <= c_valid_ff;
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               d_ctrl_ff[g]   <= c_ctrl_ff;
               d_neg_re_ff[g] <= c_neg_re_ff;
               d_neg_im_ff[g] <= c_neg_im_ff;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) begin
               d_valid_ff[g] <= 1'b0;
            end else if (en) begin
               d_valid_ff[g] <= d_valid_ff[g-1];
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               d_ctrl_ff[g]   <= d_ctrl_ff[g-1];
               d_neg_re_ff[g] <= d_neg_re_ff[g-1];
               d_neg_im_ff[g] <= d_neg_im_ff[g-1];
            end
         end
      end
   end

   // saturation: returns {overflow, value}
   function automatic logic [W:0] sat_part(input logic neg, input logic [M_W-1:0] mag);
      logic [M_W-1:0] negm;
      negm = -mag;
      if (!neg && (mag > POS_LIM)) begin
         sat_part = {1'b1, POS_LIM[W-1:0]};
      end else if (neg && (mag > NEG_LIM)) begin
         sat_part = {1'b1, NEG_LIM[W-1:0]};
      end else if (neg) begin
         sat_part = {1'b0, negm[W-1:0]};
      end else begin
         sat_part = {1'b0, mag[W-1:0]};
      end
   endfunction

   logic [W:0]   re_sat, im_sat;
   logic [W-1:0] re_fin, im_fin;
   logic         ov_fin, dz_fin;

   always_comb begin
      re_sat = sat_part(d_neg_re_ff[M_W-1], re_quo);
      im_sat = sat_part(d_neg_im_ff[M_W-1], im_quo);
      dz_fin = d_ctrl_ff[M_W-1].dz;
      if (dz_fin) begin
         re_fin = '0;
         im_fin = '0;
         ov_fin = 1'b0;
      end else begin
         re_fin = re_sat[W-1:0];
         im_fin = im_sat[W-1:0];
         ov_fin = re_sat[W] || im_sat[W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= d_valid_ff[M_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_re <= re_fin;
         out_im <= im_fin;
         out_ov <= ov_fin;
         out_dz <= dz_fin;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/complex_arith_unit_core.sv =====
// complex arithmetic unit: add, subtract, multiply and divide on Q-format complex pairs
// throughput one beat per cycle while rsp_stall does not hold the back end, set by the
// fully pipelined divider lanes (one bit a stage); every command takes the same path
// reset: synchronous, active high; clears all valid flags and queue pointers, no data cleared
// depends on cau_pkg, cau_front, cau_queue, cau_div, cau_back
`default_nettype none

module complex_arith_unit_core #(
   parameter int DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH,
   parameter int FRAC_BITS  = cau_pkg::CAU_FRAC_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_command,
   input  wire logic [DATA_WIDTH-1:0] req_a_real,
   input  wire logic [DATA_WIDTH-1:0] req_a_imag,
   input  wire logic [DATA_WIDTH-1:0] req_b_real,
   input  wire logic [DATA_WIDTH-1:0] req_b_imag,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [DATA_WIDTH-1:0]      rsp_res_real,
   output logic [DATA_WIDTH-1:0]      rsp_res_imag,
   output logic                       rsp_overflow,
   output logic                       rsp_div_by_zero
);
   import cau_pkg::*;

   localparam int W    = DATA_WIDTH;
   localparam int CT_W = $bits(ctrl_type);
   localparam int Q_W  = CT_W + 4 * W;

   // front end: one input register, tags divide-by-zero early
   logic           push, q_full;
   ctrl_type       f_ctrl;
   logic [W-1:0]   f_ar, f_ai, f_br, f_bi;

   cau_front #(.W(W)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .in_cmd   (req_command),
      .in_ar    (req_a_real),
      .in_ai    (req_a_imag),
      .in_br    (req_b_real),
      .in_bi    (req_b_imag),
      .push     (push),
      .q_full   (q_full),
      .out_ctrl (f_ctrl),
      .out_ar   (f_ar),
      .out_ai   (f_ai),
      .out_br   (f_br),
      .out_bi   (f_bi)
   );

   // queue decouples front stalls from back stalls
   logic           pop, q_not_empty, b_ready;
   logic [Q_W-1:0] q_in, q_out;
   ctrl_type       b_ctrl;
   logic [W-1:0]   b_ar, b_ai, b_br, b_bi;

   assign q_in = {f_ctrl, f_ar, f_ai, f_br, f_bi};
   assign pop  = q_not_empty && b_ready;
   assign {b_ctrl, b_ar, b_ai, b_br, b_bi} = q_out;

   cau_queue #(.WIDTH(Q_W), .DEPTH(CAU_QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .pop_data  (q_out)
   );

   // back end: whole pipeline moves together, held while the output beat waits
   cau_back #(.W(W), .F(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop),
      .in_ready  (b_ready),
      .in_ctrl   (b_ctrl),
      .in_ar     (b_ar),
      .in_ai     (b_ai),
      .in_br     (b_br),
      .in_bi     (b_bi),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_re    (rsp_res_real),
      .out_im    (rsp_res_imag),
      .out_ov    (rsp_overflow),
      .out_dz    (rsp_div_by_zero)
   );

   // a zero divisor gives a clean zero result
   a_dz_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_by_zero |->
         !rsp_overflow && rsp_res_real == '0 && rsp_res_imag == '0)
      else $error("divide-by-zero beat carries non-zero result");

   // saturation always lands on an extreme value
   a_ov_extreme : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         rsp_res_real == {1'b0, {(W-1){1'b1}}} || rsp_res_real == {1'b1, {(W-1){1'b0}}} ||
         rsp_res_imag == {1'b0, {(W-1){1'b1}}} || rsp_res_imag == {1'b1, {(W-1){1'b0}}})
      else $error("overflow flagged without a saturated part");

   // nothing comes out straight after reset
   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat right after reset");

endmodule

`default_nettype wire
